/* hw/rtl/pkf_pkg.sv */
// pkf_pkg: constants, register codes and types of the per-pixel kalman fusion block
// used by the channel interfaces and the top level
`timescale 1ns / 1ps
`default_nettype none

package pkf_pkg;

	// variance store, one entry per pixel (power of two)
	localparam int PIXEL_COUNT = 524288;
	localparam int ADDR_W      = $clog2(PIXEL_COUNT);

	// field widths
	localparam int PIX_IDX_W = 19;
	localparam int PRED_W    = 16;
	localparam int OBS_W     = 8;
	localparam int BLUR_W    = 8;
	localparam int BERR_W    = 24;
	localparam int FUSED_W   = 16;

	// arithmetic widths
	localparam int VAR_W   = 24;
	localparam int S_W     = VAR_W + 1;
	localparam int DEN_W   = 26;
	localparam int KQ_W    = 17;
	localparam int RPROD_W = 32;

	localparam logic [VAR_W-1:0] VAR_RESET = VAR_W'(256000);
	localparam logic [VAR_W-1:0] Q_STILL   = VAR_W'(2560);
	localparam logic [DEN_W-1:0] TENTH_Q8  = DEN_W'(26);

	// configuration registers
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_STILL_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MEAS_SCALE = 1'd1;
	localparam logic [15:0] MEAS_SCALE_RESET = 16'd6636;

	// divider depth: one quotient bit per stage
	localparam int DIV_STAGES = KQ_W;

	typedef struct packed {
		logic [ADDR_W-1:0] idx;
		logic [PRED_W-1:0] pred;
		logic [OBS_W-1:0]  obs;
		logic              pv;
		logic              ov;
	} ctx_t;

endpackage

`default_nettype wire

/* hw/rtl/pkf_if.sv */
// pkf_in_if / pkf_out_if: valid-ready channels carrying one pixel word and one fused word
// depends on pkf_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface pkf_in_if;
	logic                             valid;
	logic                             ready;
	logic [pkf_pkg::PIX_IDX_W-1:0]    pixel_index;
	logic [pkf_pkg::PRED_W-1:0]       predicted_value;
	logic [pkf_pkg::OBS_W-1:0]        observed_value;
	logic [pkf_pkg::BLUR_W-1:0]       blurred_observed;
	logic [pkf_pkg::BERR_W-1:0]       block_error;
	logic                             predict_valid;
	logic                             observe_valid;

	modport source (
		output valid, pixel_index, predicted_value, observed_value, blurred_observed,
		output block_error, predict_valid, observe_valid,
		input  ready
	);
	modport sink (
		input  valid, pixel_index, predicted_value, observed_value, blurred_observed,
		input  block_error, predict_valid, observe_valid,
		output ready
	);
endinterface

interface pkf_out_if;
	logic                          valid;
	logic                          ready;
	logic [pkf_pkg::FUSED_W-1:0]   fused_value;
	logic                          fused_valid;

	modport source (output valid, fused_value, fused_valid, input ready);
	modport sink (input valid, fused_value, fused_valid, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pkf_ram.sv */
// pkf_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module pkf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/per_pixel_kalman_fusion.sv */
// per_pixel_kalman_fusion: per-pixel scalar kalman update with fused pixel output
// depends on pkf_pkg, pkf_if (pkf_in_if, pkf_out_if) and pkf_ram
// pipeline: 5 front stages, 17 divide steps, a write-back stage and the output register; the
// first front stage loads at the accepting edge
// throughput: one word per cycle while the output is not stalled; a word whose pixel index is still
// in flight waits until that entry is written back to the variance ram
// reset: control clears at once, then a clearing pass writes all PIXEL_COUNT (524288) variance
// entries to 1000 while no word is accepted; config writes are taken throughout
`timescale 1ns / 1ps
`default_nettype none

module per_pixel_kalman_fusion (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	pkf_in_if.sink                                  pix_in,
	pkf_out_if.source                               pix_out,
	input  wire logic                               cfg_we,
	input  wire logic [pkf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [pkf_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int AW = pkf_pkg::ADDR_W;
	localparam int ND = pkf_pkg::DIV_STAGES;

	// config
	logic        still_mode_q;
	logic [15:0] meas_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			still_mode_q <= 1'b0;
			meas_scale_q <= pkf_pkg::MEAS_SCALE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				pkf_pkg::REG_STILL_MODE: still_mode_q <= cfg_data[0];
				pkf_pkg::REG_MEAS_SCALE: meas_scale_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// clearing pass
	logic          clearing_q;
	logic [AW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(pkf_pkg::PIXEL_COUNT - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// pipeline registers
	logic                            v_s1, v_s2, v_s3, v_s4, v_s5, v_s7;
	pkf_pkg::ctx_t                   ctx_s1, ctx_s2, ctx_s3, ctx_s4, ctx_s5, ctx_s7;
	logic [pkf_pkg::BLUR_W-1:0]      blur_s1;
	logic [pkf_pkg::BERR_W-1:0]      berr_s1;
	logic [15:0]                     blur2_s2;
	logic [pkf_pkg::S_W-1:0]         s_s2, s_s3, s_s4, s_s5;
	logic [pkf_pkg::RPROD_W-1:0]     rprod_s3;
	logic [pkf_pkg::DEN_W-1:0]       den_s4, den_s5;
	logic [pkf_pkg::DEN_W-1:0]       rem_s5;
	logic [pkf_pkg::KQ_W-1:0]        nlow_s5;
	logic [41:0]                     pp_s7;
	logic signed [33:0]              fp_s7;

	// divider stages s6 (one quotient bit each)
	logic                            dv_v_s6    [ND];
	pkf_pkg::ctx_t                   dv_ctx_s6  [ND];
	logic [pkf_pkg::S_W-1:0]         dv_s_s6    [ND];
	logic [pkf_pkg::DEN_W-1:0]       dv_den_s6  [ND];
	logic [pkf_pkg::DEN_W-1:0]       dv_rem_s6  [ND];
	logic [pkf_pkg::KQ_W-1:0]        dv_nlow_s6 [ND];
	logic [pkf_pkg::KQ_W-1:0]        dv_quo_s6  [ND];

	// output register
	logic                            out_valid_q;
	logic [pkf_pkg::FUSED_W-1:0]     fused_value_q;
	logic                            fused_valid_q;

	logic          en;
	logic          conflict;
	logic          accept;
	logic [AW-1:0] in_idx;
	logic [pkf_pkg::VAR_W-1:0] p_rd;

	assign en     = !out_valid_q || pix_out.ready;
	assign in_idx = pix_in.pixel_index[AW-1:0];

	// interlock: incoming pixel must not be in flight anywhere before write-back
	always_comb begin
		conflict = (v_s1 && ctx_s1.idx == in_idx) || (v_s2 && ctx_s2.idx == in_idx) ||
		           (v_s3 && ctx_s3.idx == in_idx) || (v_s4 && ctx_s4.idx == in_idx) ||
		           (v_s5 && ctx_s5.idx == in_idx) || (v_s7 && ctx_s7.idx == in_idx);
		for (int j = 0; j < ND; j++) begin
			if (dv_v_s6[j] && dv_ctx_s6[j].idx == in_idx) begin
				conflict = 1'b1;
			end
		end
	end

	assign pix_in.ready = en && !clearing_q && !conflict;
	assign accept       = pix_in.valid && pix_in.ready;

	// write-back arithmetic at the end of the pipe
	logic [42:0]               np_sum;
	logic [26:0]               np_full;
	logic [pkf_pkg::VAR_W-1:0] np;
	logic signed [34:0]        acc;
	logic [pkf_pkg::FUSED_W-1:0] fused_mix;
	logic [pkf_pkg::FUSED_W-1:0] fused_nxt;
	logic                      fvalid_nxt;

	always_comb begin
		np_sum  = {1'b0, pp_s7} + 43'd32768;
		np_full = np_sum[42:16];
		np      = (np_full > 27'(24'hFFFFFF)) ? 24'hFFFFFF : np_full[pkf_pkg::VAR_W-1:0];

		acc = $signed({3'b000, ctx_s7.pred, 16'h0000}) + 35'(fp_s7) + 35'sd32768;
		if (acc < 0) begin
			fused_mix = '0;
		end else if (acc[34:16] > 19'd65535) begin
			fused_mix = 16'hFFFF;
		end else begin
			fused_mix = acc[31:16];
		end

		fvalid_nxt = ctx_s7.pv || ctx_s7.ov;
		if (ctx_s7.pv && ctx_s7.ov) begin
			fused_nxt = fused_mix;
		end else if (ctx_s7.pv) begin
			fused_nxt = ctx_s7.pred;
		end else if (ctx_s7.ov) begin
			fused_nxt = {ctx_s7.obs, 8'h00};
		end else begin
			fused_nxt = '0;
		end
	end

	// variance store
	logic                      ram_we;
	logic [AW-1:0]             ram_waddr;
	logic [pkf_pkg::VAR_W-1:0] ram_wdata;

	assign ram_we    = clearing_q || (v_s7 && en);
	assign ram_waddr = clearing_q ? clr_addr_q : ctx_s7.idx;
	assign ram_wdata = clearing_q ? pkf_pkg::VAR_RESET : np;

	pkf_ram #(
		.WIDTH (pkf_pkg::VAR_W),
		.DEPTH (pkf_pkg::PIXEL_COUNT)
	) u_var_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (accept),
		.rd_addr (in_idx),
		.rd_data (p_rd)
	);

	// front stages
	logic [pkf_pkg::VAR_W-1:0] q_s1;
	logic [32:0]               r_sum;
	logic [24:0]               r_s3;
	logic [41:0]               num_s4;

	always_comb begin
		q_s1   = still_mode_q ? pkf_pkg::Q_STILL : berr_s1;
		r_sum  = {1'b0, rprod_s3} + 33'd128;
		r_s3   = r_sum[32:8];
		num_s4 = {1'b0, s_s4, 16'h0000} + 42'(den_s4[pkf_pkg::DEN_W-1:1]);
	end

	// divider step: shift in one dividend bit, subtract when it fits
	function automatic logic [pkf_pkg::DEN_W:0] div_step(
		input logic [pkf_pkg::DEN_W-1:0] rem,
		input logic                      nbit,
		input logic [pkf_pkg::DEN_W-1:0] den
	);
		logic [pkf_pkg::DEN_W:0] t;
		logic [pkf_pkg::DEN_W:0] d;
		t = {rem, nbit};
		d = {1'b0, den};
		if (t >= d) begin
			div_step = {1'b1, pkf_pkg::DEN_W'(t - d)};
		end else begin
			div_step = {1'b0, t[pkf_pkg::DEN_W-1:0]};
		end
	endfunction

	// gain clamp and products
	logic [pkf_pkg::KQ_W-1:0] k_raw;
	logic [15:0]              k;
	logic [pkf_pkg::KQ_W-1:0] one_minus_k;
	logic signed [16:0]       diff;

	always_comb begin
		k_raw       = dv_quo_s6[ND-1];
		k           = k_raw[16] ? 16'hFFFF : k_raw[15:0];
		one_minus_k = 17'h10000 - {1'b0, k};
		diff        = $signed({1'b0, dv_ctx_s6[ND-1].obs, 8'h00}) -
		              $signed({1'b0, dv_ctx_s6[ND-1].pred});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s7 <= 1'b0;
			out_valid_q <= 1'b0;
			for (int j = 0; j < ND; j++) begin
				dv_v_s6[j] <= 1'b0;
			end
		end else if (en) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			dv_v_s6[0] <= v_s5;
			for (int j = 1; j < ND; j++) begin
				dv_v_s6[j] <= dv_v_s6[j-1];
			end
			v_s7 <= dv_v_s6[ND-1];
			out_valid_q <= v_s7;
		end
	end

	logic [pkf_pkg::DEN_W:0] st0;
	assign st0 = div_step(rem_s5, nlow_s5[pkf_pkg::KQ_W-1], den_s5);

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1.idx  <= in_idx;
			ctx_s1.pred <= pix_in.predicted_value;
			ctx_s1.obs  <= pix_in.observed_value;
			ctx_s1.pv   <= pix_in.predict_valid;
			ctx_s1.ov   <= pix_in.observe_valid;
			blur_s1     <= pix_in.blurred_observed;
			berr_s1     <= pix_in.block_error;

			ctx_s2   <= ctx_s1;
			s_s2     <= {1'b0, p_rd} + {1'b0, q_s1};
			blur2_s2 <= blur_s1 * blur_s1;

			ctx_s3   <= ctx_s2;
			s_s3     <= s_s2;
			rprod_s3 <= 32'(blur2_s2) * 32'(meas_scale_q);

			ctx_s4 <= ctx_s3;
			s_s4   <= s_s3;
			den_s4 <= pkf_pkg::DEN_W'(s_s3) + pkf_pkg::DEN_W'(r_s3) + pkf_pkg::TENTH_Q8;

			ctx_s5  <= ctx_s4;
			s_s5    <= s_s4;
			den_s5  <= den_s4;
			rem_s5  <= {1'b0, num_s4[41:17]};
			nlow_s5 <= num_s4[16:0];

			dv_ctx_s6[0]  <= ctx_s5;
			dv_s_s6[0]    <= s_s5;
			dv_den_s6[0]  <= den_s5;
			dv_rem_s6[0]  <= st0[pkf_pkg::DEN_W-1:0];
			dv_nlow_s6[0] <= {nlow_s5[pkf_pkg::KQ_W-2:0], 1'b0};
			dv_quo_s6[0]  <= {{(pkf_pkg::KQ_W-1){1'b0}}, st0[pkf_pkg::DEN_W]};
			for (int j = 1; j < ND; j++) begin
				logic [pkf_pkg::DEN_W:0] st;
				st = div_step(dv_rem_s6[j-1], dv_nlow_s6[j-1][pkf_pkg::KQ_W-1], dv_den_s6[j-1]);
				dv_ctx_s6[j]  <= dv_ctx_s6[j-1];
				dv_s_s6[j]    <= dv_s_s6[j-1];
				dv_den_s6[j]  <= dv_den_s6[j-1];
				dv_rem_s6[j]  <= st[pkf_pkg::DEN_W-1:0];
				dv_nlow_s6[j] <= {dv_nlow_s6[j-1][pkf_pkg::KQ_W-2:0], 1'b0};
				dv_quo_s6[j]  <= {dv_quo_s6[j-1][pkf_pkg::KQ_W-2:0], st[pkf_pkg::DEN_W]};
			end

			ctx_s7 <= dv_ctx_s6[ND-1];
			pp_s7  <= 42'(one_minus_k) * 42'(dv_s_s6[ND-1]);
			fp_s7  <= 34'($signed({1'b0, k}) * diff);

			fused_value_q <= fused_nxt;
			fused_valid_q <= fvalid_nxt;
		end
	end

	assign pix_out.valid       = out_valid_q;
	assign pix_out.fused_value = fused_value_q;
	assign pix_out.fused_valid = fused_valid_q;

	// two adjacent in-flight words never address the same pixel
	a_no_dup_idx: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s2 |-> ctx_s1.idx != ctx_s2.idx)
		else $error("same pixel in flight twice");

	// clearing pass runs once after reset
	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		!clearing_q |=> !clearing_q)
		else $error("clearing pass restarted");

	// first stage and write-back stage are empty while the store is being cleared
	a_no_wb_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !v_s7 && !v_s1)
		else $error("write-back during clearing pass");

	// invalid results carry a zero pixel
	a_zero_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		pix_out.valid && !pix_out.fused_valid |-> pix_out.fused_value == '0)
		else $error("invalid result with nonzero value");

endmodule

`default_nettype wire
